// ===== src/ips_pkg.sv =====
// Shared types and constants for the image part synchronizer.
package ips_pkg;

	localparam int MAX_IMAGES_DEF = 16;
	localparam int ID_W           = 64;
	localparam int CNT_W          = 8;
	localparam int LIM_W          = 5;
	localparam int CORR_W         = 5;
	localparam int CFG_W          = 8;
	localparam int CFG_IDX_W      = 1;

	localparam logic [CFG_IDX_W-1:0] REG_PARTS_PER_IMAGE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LIMIT    = 1'd1;

	localparam logic [CNT_W-1:0] PARTS_RESET = 8'd1;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_SHIFT,
		OP_LOAD,
		OP_BUMP
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_SHIFT
	} state_t;

endpackage

// ===== src/ips_cell.sv =====
// One list slot: image identifier and part count, with its own match logic.
module ips_cell (
	input  logic                          clk,
	input  ips_pkg::cell_op_t             op,
	input  logic                          live,
	input  logic [ips_pkg::ID_W-1:0]      key,
	input  logic [ips_pkg::ID_W-1:0]      nb_id,
	input  logic [ips_pkg::CNT_W-1:0]     nb_cnt,
	input  logic [ips_pkg::CNT_W-1:0]     parts,
	output logic [ips_pkg::ID_W-1:0]      id,
	output logic [ips_pkg::CNT_W-1:0]     cnt,
	output logic                          hit,
	output logic                          done
);

	logic [ips_pkg::ID_W-1:0]  id_q;
	logic [ips_pkg::CNT_W-1:0] cnt_q;
	logic [ips_pkg::CNT_W-1:0] cnt_inc;

	assign cnt_inc = cnt_q + ips_pkg::CNT_W'(1);

	always_ff @(posedge clk) begin
		case (op)
			ips_pkg::OP_HOLD: begin
			end
			ips_pkg::OP_SHIFT: begin
				id_q  <= nb_id;
				cnt_q <= nb_cnt;
			end
			ips_pkg::OP_LOAD: begin
				id_q  <= key;
				cnt_q <= ips_pkg::CNT_W'(1);
			end
			ips_pkg::OP_BUMP: begin
				cnt_q <= cnt_inc;
			end
			default: begin
			end
		endcase
	end

	assign id   = id_q;
	assign cnt  = cnt_q;
	// count wraps at 8 bits, so a setting of zero completes after 256 parts
	assign hit  = live && (id_q == key);
	assign done = hit && (cnt_inc == parts);

endmodule

// ===== src/image_part_synchronizer_core.sv =====
// Top level of the image part synchronizer: control, configuration and result register.
//
// The block tracks pending images in a row of MAX_IMAGES slots, oldest in slot 0.
// A notice is taken while the block is idle and matched against all live slots in the
// next cycle, or later while the result register is still full. When a notice completes
// an image that sits in slot k, the slots up to and including k are discarded by shifting
// the row one slot per cycle toward slot 0; there is no shift when the list empties.
// A new image that has to push out the oldest entry is appended during the same shift,
// at no extra cost. The result goes to an output register; while it waits on out_stall
// the next notice is still taken, but the match cycle holds until the register is free.
// parts_per_image and buffer_limit may only be written while the block is idle;
// buffer_limit is clamped into 1..MAX_IMAGES.
module image_part_synchronizer_core #(
	parameter int MAX_IMAGES = ips_pkg::MAX_IMAGES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ips_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ips_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ips_pkg::ID_W-1:0]          notice_id,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              complete,
	output logic [ips_pkg::ID_W-1:0]          done_image_id,
	output logic [ips_pkg::CORR_W-1:0]        corrupted_count
);

	localparam int SW = $clog2(MAX_IMAGES + 1);
	localparam int IW = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
	localparam int CW = (SW > ips_pkg::LIM_W) ? SW : ips_pkg::LIM_W;

	// configuration
	logic [ips_pkg::CNT_W-1:0] parts_q;
	logic [ips_pkg::LIM_W-1:0] limit_q;
	logic [CW-1:0]             lim_eff;

	// control state
	ips_pkg::state_t state_q, state_n;
	logic [SW-1:0]   size_q, size_n;
	logic [SW-1:0]   shift_q, shift_n;
	logic [ips_pkg::ID_W-1:0] key_q;

	// result register
	logic                       out_valid_q;
	logic                       complete_q;
	logic [ips_pkg::ID_W-1:0]   done_id_q;
	logic [ips_pkg::CORR_W-1:0] corr_q;
	logic                       res_load;
	logic                       res_complete;
	logic [ips_pkg::ID_W-1:0]   res_id;
	logic [ips_pkg::CORR_W-1:0] res_corr;

	// cell row
	ips_pkg::cell_op_t          cell_op  [MAX_IMAGES];
	logic [ips_pkg::ID_W-1:0]   cell_id  [MAX_IMAGES];
	logic [ips_pkg::CNT_W-1:0]  cell_cnt [MAX_IMAGES];
	logic [MAX_IMAGES-1:0]      cell_live;
	logic [MAX_IMAGES-1:0]      cell_hit;
	logic [MAX_IMAGES-1:0]      cell_done;

	logic          found;
	logic          done_any;
	logic [IW-1:0] hit_idx;
	logic          drop;
	logic [SW-1:0] new_pos;
	logic          out_free;
	logic          in_acc;

	// clamp the limit into 1..MAX_IMAGES
	always_comb begin
		if (limit_q == '0)
			lim_eff = CW'(1);
		else if (CW'(limit_q) > CW'(MAX_IMAGES))
			lim_eff = CW'(MAX_IMAGES);
		else
			lim_eff = CW'(limit_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parts_q <= ips_pkg::PARTS_RESET;
			limit_q <= ips_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ips_pkg::REG_PARTS_PER_IMAGE: parts_q <= cfg_data;
				ips_pkg::REG_BUFFER_LIMIT:    limit_q <= cfg_data[ips_pkg::LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// row of slots; the last slot shifts in its own contents
	for (genvar i = 0; i < MAX_IMAGES; i++) begin : g_cell
		logic [ips_pkg::ID_W-1:0]  nb_id;
		logic [ips_pkg::CNT_W-1:0] nb_cnt;

		if (i == MAX_IMAGES - 1) begin : g_tail
			assign nb_id  = cell_id[i];
			assign nb_cnt = cell_cnt[i];
		end else begin : g_body
			assign nb_id  = cell_id[i+1];
			assign nb_cnt = cell_cnt[i+1];
		end

		assign cell_live[i] = SW'(i) < size_q;

		ips_cell u_cell (
			.clk    (clk),
			.op     (cell_op[i]),
			.live   (cell_live[i]),
			.key    (key_q),
			.nb_id  (nb_id),
			.nb_cnt (nb_cnt),
			.parts  (parts_q),
			.id     (cell_id[i]),
			.cnt    (cell_cnt[i]),
			.hit    (cell_hit[i]),
			.done   (cell_done[i])
		);
	end

	// identifiers in the list are unique, so the hit vector is one-hot or empty
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < MAX_IMAGES; i++) begin
			if (cell_hit[i])
				hit_idx = hit_idx | IW'(i);
		end
	end

	assign found    = |cell_hit;
	assign done_any = |cell_done;
	assign drop     = CW'(size_q) >= lim_eff;
	// slot the new image lands in, after an optional drop of the oldest
	assign new_pos  = drop ? (size_q - SW'(1)) : size_q;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ips_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		state_n      = state_q;
		size_n       = size_q;
		shift_n      = shift_q;
		res_load     = 1'b0;
		res_complete = 1'b0;
		res_id       = '0;
		res_corr     = '0;
		for (int i = 0; i < MAX_IMAGES; i++)
			cell_op[i] = ips_pkg::OP_HOLD;

		case (state_q)
			ips_pkg::ST_IDLE: begin
				if (in_acc)
					state_n = ips_pkg::ST_MATCH;
			end
			ips_pkg::ST_MATCH: begin
				if (out_free) begin
					res_load = 1'b1;
					state_n  = ips_pkg::ST_IDLE;
					if (found) begin
						if (done_any) begin
							// pop the completed image and everything older
							res_complete = 1'b1;
							res_id       = key_q;
							res_corr     = ips_pkg::CORR_W'(hit_idx);
							size_n       = size_q - (SW'(hit_idx) + SW'(1));
							shift_n      = SW'(hit_idx) + SW'(1);
							if (size_n != '0)
								state_n = ips_pkg::ST_SHIFT;
						end else begin
							for (int i = 0; i < MAX_IMAGES; i++)
								if (cell_hit[i])
									cell_op[i] = ips_pkg::OP_BUMP;
						end
					end else if (parts_q == ips_pkg::CNT_W'(1)) begin
						// new image completes at once: the whole list goes
						res_complete = 1'b1;
						res_id       = key_q;
						res_corr     = ips_pkg::CORR_W'(new_pos);
						size_n       = '0;
					end else if (drop) begin
						// advance the row by one and append at the tail
						res_corr = ips_pkg::CORR_W'(1);
						for (int i = 0; i < MAX_IMAGES; i++)
							cell_op[i] = (SW'(i) == new_pos) ? ips_pkg::OP_LOAD
							                                 : ips_pkg::OP_SHIFT;
					end else begin
						for (int i = 0; i < MAX_IMAGES; i++)
							if (SW'(i) == new_pos)
								cell_op[i] = ips_pkg::OP_LOAD;
						size_n = size_q + SW'(1);
					end
				end
			end
			ips_pkg::ST_SHIFT: begin
				for (int i = 0; i < MAX_IMAGES; i++)
					cell_op[i] = ips_pkg::OP_SHIFT;
				shift_n = shift_q - SW'(1);
				if (shift_q == SW'(1))
					state_n = ips_pkg::ST_IDLE;
			end
			default: begin
				state_n = ips_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ips_pkg::ST_IDLE;
			size_q      <= '0;
			shift_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			size_q  <= size_n;
			shift_q <= shift_n;
			if (res_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers: hold the notice and the result transaction
	always_ff @(posedge clk) begin
		if (in_acc)
			key_q <= notice_id;
		if (res_load) begin
			complete_q <= res_complete;
			done_id_q  <= res_id;
			corr_q     <= res_corr;
		end
	end

	assign out_valid       = out_valid_q;
	assign complete        = complete_q;
	assign done_image_id   = done_id_q;
	assign corrupted_count = corr_q;

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= SW'(MAX_IMAGES))
		else $error("pending list longer than the row");

	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ips_pkg::ST_SHIFT |-> shift_q != '0)
		else $error("shift state with no shifts left");

	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ips_pkg::ST_MATCH |-> $onehot0(cell_hit))
		else $error("identifier matched more than one slot");

	a_idle_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !complete_q |-> done_id_q == '0)
		else $error("identifier shown without completion");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ips_pkg::ST_SHIFT |=> state_q != ips_pkg::ST_MATCH)
		else $error("notice taken during row shift");

endmodule

// ===== sim/tb_image_part_synchronizer_core.sv =====
// Self-checking testbench for image_part_synchronizer_core with a built-in list predictor.
module tb_image_part_synchronizer_core;

	localparam int SLOTS        = ips_pkg::MAX_IMAGES_DEF;
	// The block may still be shifting slots after its last result is taken.
	localparam int SETTLE_TIME  = SLOTS + 4;
	localparam int HOLD_OFF_LEN = 300;
	localparam int QUIET_LIMIT  = 4000;

	typedef struct packed {
		logic                       complete;
		logic [ips_pkg::ID_W-1:0]   done_id;
		logic [ips_pkg::CORR_W-1:0] dropped;
	} sync_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [ips_pkg::CFG_IDX_W-1:0] cfg_index = ips_pkg::REG_PARTS_PER_IMAGE;
	logic [ips_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [ips_pkg::ID_W-1:0]      notice_id = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          complete;
	logic [ips_pkg::ID_W-1:0]      done_image_id;
	logic [ips_pkg::CORR_W-1:0]    corrupted_count;

	image_part_synchronizer_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.notice_id       (notice_id),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.complete        (complete),
		.done_image_id   (done_image_id),
		.corrupted_count (corrupted_count)
	);

	always #5 clk = ~clk;

	// Predictor state: pending images oldest first, with their part counts.
	logic [ips_pkg::ID_W-1:0]  live_id [SLOTS];
	logic [ips_pkg::CNT_W-1:0] live_cnt [SLOTS];
	int                        live_count = 0;
	logic [ips_pkg::CNT_W-1:0] parts_setting = ips_pkg::PARTS_RESET;
	logic [ips_pkg::LIM_W-1:0] limit_setting = ips_pkg::LIMIT_RESET;

	logic [ips_pkg::ID_W-1:0] notice_q [$];     // image ids waiting to be driven
	sync_result_t             expected_q [$];   // predicted results, oldest first

	int err_count = 0;
	int quiet_cycles = 0;
	bit calm_mode = 1'b0;      // no idling on either side
	bit sender_hold = 1'b0;    // stop launching new notices
	int hold_off_reqs = 0;     // bumped to ask the receiver for a long stall

	// Append one notice to the send queue.
	function automatic void add_notice(input logic [ips_pkg::ID_W-1:0] id);
		notice_q.insert(notice_q.size(), id);
	endfunction

	// Drop the n oldest pending images.
	function automatic void discard_oldest(input int n);
		int cnt;
		cnt = (n > live_count) ? live_count : n;
		for (int i = 0; i + cnt < live_count; i++) begin
			live_id[i] = live_id[i + cnt];
			live_cnt[i] = live_cnt[i + cnt];
		end
		live_count -= cnt;
	endfunction

	// Apply one part notice to the pending list and return the result it causes.
	function automatic sync_result_t track_notice(input logic [ips_pkg::ID_W-1:0] id);
		sync_result_t res;
		int slot;
		int lim;
		bit found;
		bit dropped;
		found = 1'b0;
		dropped = 1'b0;
		slot = 0;
		for (int i = 0; i < live_count; i++)
			if (!found && live_id[i] == id) begin
				found = 1'b1;
				slot = i;
			end
		if (!found) begin
			// Clamp the limit into 1..SLOTS; a lowered limit still drops only one entry.
			lim = int'(limit_setting);
			if (lim < 1) lim = 1;
			if (lim > SLOTS) lim = SLOTS;
			if (live_count + 1 > lim) begin
				discard_oldest(1);
				dropped = 1'b1;
			end
			slot = live_count;
			live_id[slot] = id;
			live_cnt[slot] = '0;
			live_count++;
		end
		// The 8-bit count wraps, so a setting of zero or below the count still completes.
		live_cnt[slot] = live_cnt[slot] + ips_pkg::CNT_W'(1);
		if (live_cnt[slot] == parts_setting) begin
			discard_oldest(slot + 1);
			res.complete = 1'b1;
			res.done_id = id;
			res.dropped = slot[ips_pkg::CORR_W-1:0];
		end else begin
			res.complete = 1'b0;
			res.done_id = '0;
			res.dropped = {{(ips_pkg::CORR_W-1){1'b0}}, dropped};
		end
		return res;
	endfunction

	function automatic logic [ips_pkg::ID_W-1:0] rand_id();
		return {$urandom, $urandom};
	endfunction

	// Driver: predict on each accepted transaction, then hold or advance the payload.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_q.insert(expected_q.size(), track_notice(notice_id));
			if (!in_valid || !in_stall) begin
				if (notice_q.size() > 0 && !sender_hold &&
				    (calm_mode || $urandom_range(99) >= 32)) begin
					in_valid <= 1'b1;
					notice_id <= notice_q[0];
					notice_q.delete(0);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result, and drive the receiver's stall.
	int hold_seen = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		sync_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("result with nothing expected: complete=%0b id=%h dropped=%0d",
					       complete, done_image_id, corrupted_count);
					err_count++;
				end else begin
					want = expected_q[0];
					expected_q.delete(0);
					if (complete !== want.complete) begin
						$error("complete: expected %0b, got %0b", want.complete, complete);
						err_count++;
					end
					if (done_image_id !== want.done_id) begin
						$error("done_image_id: expected %h, got %h", want.done_id,
						       done_image_id);
						err_count++;
					end
					if (corrupted_count !== want.dropped) begin
						$error("corrupted_count: expected %0d, got %0d", want.dropped,
						       corrupted_count);
						err_count++;
					end
				end
			end
			// A hold-off request stalls the output long enough to back the block up.
			if (hold_seen != hold_off_reqs) begin
				hold_seen = hold_off_reqs;
				hold_left = HOLD_OFF_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm_mode && ($urandom_range(99) < 32);
			end
		end
	end

	// Watchdog: end the run if no transaction moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Write one register; only called while the block is idle.
	task automatic write_reg(input logic [ips_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [ips_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ips_pkg::REG_PARTS_PER_IMAGE)
			parts_setting = val;
		else
			limit_setting = val[ips_pkg::LIM_W-1:0];
	endtask

	// Wait until every notice is taken and answered, then let the slot shift finish.
	task automatic settle();
		while (notice_q.size() > 0 || in_valid || expected_q.size() > 0)
			@(negedge clk);
		repeat (SETTLE_TIME) @(negedge clk);
	endtask

	// Queue interleaved part streams: mostly well-formed images, some abandoned, some noise.
	task automatic queue_image_traffic(input int n, input int window);
		logic [ips_pkg::ID_W-1:0] img_q [$];
		int left_q [$];
		int need;
		int sent;
		int pick;
		int idx;
		need = (parts_setting == 0) ? 256 : int'(parts_setting);
		sent = 0;
		while (sent < n) begin
			while (img_q.size() < window) begin
				img_q.insert(img_q.size(), rand_id());
				left_q.insert(left_q.size(), need);
			end
			pick = $urandom_range(99);
			if (pick < 82) begin
				// Favor the oldest image so most complete in order.
				idx = (pick < 50) ? 0 : $urandom_range(img_q.size() - 1);
				add_notice(img_q[idx]);
				left_q[idx]--;
				if (left_q[idx] == 0) begin
					img_q.delete(idx);
					left_q.delete(idx);
				end
				sent++;
			end else if (pick < 90) begin
				// Abandon an image; the block drops or flushes it later.
				img_q.delete(0);
				left_q.delete(0);
			end else begin
				add_notice(rand_id());
				sent++;
			end
		end
	endtask

	task automatic run_phase(input logic [ips_pkg::CFG_W-1:0] parts,
	                         input logic [ips_pkg::CFG_W-1:0] lim,
	                         input int n, input int window, input bit calm,
	                         input bit hold_off, input bit pause);
		write_reg(ips_pkg::REG_PARTS_PER_IMAGE, parts);
		write_reg(ips_pkg::REG_BUFFER_LIMIT, lim);
		calm_mode = calm;
		queue_image_traffic(n, window);
		if (hold_off)
			hold_off_reqs++;
		if (pause) begin
			// Halt the sender midway until every outstanding result is back.
			while (notice_q.size() > n / 2)
				@(negedge clk);
			sender_hold = 1'b1;
			while (in_valid || expected_q.size() > 0)
				@(negedge clk);
			repeat (5) @(negedge clk);
			sender_hold = 1'b0;
		end
		settle();
		calm_mode = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: one part completes an image at once; extreme ids.
		add_notice('0);
		add_notice('1);
		add_notice('0);
		settle();

		// Overflow of a three-deep list, then completion of the newest entry.
		write_reg(ips_pkg::REG_PARTS_PER_IMAGE, 8'd2);
		write_reg(ips_pkg::REG_BUFFER_LIMIT, 8'd3);
		add_notice(64'hA5A5_0000_0000_0001);
		add_notice(64'hA5A5_0000_0000_0002);
		add_notice(64'hA5A5_0000_0000_0003);
		add_notice(64'hA5A5_0000_0000_0004);
		add_notice(64'hA5A5_0000_0000_0004);
		settle();

		// Limit of zero clamps to one.
		write_reg(ips_pkg::REG_BUFFER_LIMIT, 8'd0);
		add_notice(64'h5A5A_0000_0000_0010);
		add_notice(64'h5A5A_0000_0000_0011);
		add_notice(64'h5A5A_0000_0000_0011);
		settle();

		// Limit above the slot count clamps; fill five entries.
		write_reg(ips_pkg::REG_BUFFER_LIMIT, 8'd31);
		write_reg(ips_pkg::REG_PARTS_PER_IMAGE, 8'd3);
		for (int i = 0; i < 5; i++)
			add_notice(64'h0123_4567_89AB_CD00 + 64'(i));
		settle();

		// Limit lowered below the list length: one drop per new image only.
		write_reg(ips_pkg::REG_BUFFER_LIMIT, 8'd2);
		repeat (3) add_notice(64'hFEDC_BA98_7654_3210);
		settle();

		// Count above the setting, then a setting of zero: the count wraps to complete.
		add_notice(64'h8000_0000_0000_0001);
		add_notice(64'h8000_0000_0000_0001);
		settle();
		write_reg(ips_pkg::REG_PARTS_PER_IMAGE, 8'd0);
		repeat (254) add_notice(64'h8000_0000_0000_0001);
		settle();

		run_phase(8'd1, 8'd16, 200, 4, 1'b0, 1'b0, 1'b1);
		run_phase(8'd2, 8'd1, 120, 3, 1'b0, 1'b0, 1'b0);
		run_phase(8'd4, 8'd4, 150, 6, 1'b0, 1'b0, 1'b0);
		run_phase(8'd3, 8'd16, 200, 20, 1'b1, 1'b1, 1'b0);
		run_phase(8'd255, 8'hE8, 300, 1, 1'b0, 1'b0, 1'b0);
		repeat (4)
			run_phase(ips_pkg::CFG_W'($urandom_range(6, 1)),
			          ips_pkg::CFG_W'($urandom_range(255)), 100,
			          int'($urandom_range(18, 1)), 1'b0, 1'b0, 1'b0);

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
